// ===== hw/rtl/abr_pkg.sv =====
// Shared types and constants for the alternating-bit receiver.
`timescale 1ns / 1ps

package abr_pkg;

  // Default packet payload length in bytes
  localparam int PAYLOAD_BYTES = 20;

  // Reply text characters
  localparam logic [7:0] CHR_A = "A";
  localparam logic [7:0] CHR_C = "C";
  localparam logic [7:0] CHR_K = "K";
  localparam logic [7:0] CHR_N = "N";

  // Byte sums of the reply texts "ACK" and "NACK"
  localparam logic [31:0] ACK_TEXT_SUM = 32'(CHR_A) + 32'(CHR_C) + 32'(CHR_K);
  localparam logic [31:0] NAK_TEXT_SUM = 32'(CHR_N) + ACK_TEXT_SUM;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_WORD = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2
  } result_kind_t;

  // One input beat: a payload word with the packet header fields
  typedef struct packed {
    logic signed [31:0] seq_num;
    logic signed [31:0] ack_num;
    logic signed [31:0] check_value;
    logic        [31:0] payload_word;
    logic               last_word;
  } in_item_t;

  // One result beat: a delivered word or a reply
  typedef struct packed {
    logic        [1:0]  result_kind;
    logic        [31:0] out_word;
    logic               reply_ack;
    logic signed [31:0] reply_check;
    logic               end_of_run;
  } out_item_t;

endpackage

// ===== hw/rtl/alternating_bit_receiver.sv =====
// Alternating-bit receiver: packet check, duplicate detection, delivery and replies.
`timescale 1ns / 1ps

// Takes one payload word per cycle while in_stall is low. The header fields are
// sampled on the first word of a packet. Words are written into a two-bank
// payload memory; one bank holds the last accepted packet, the other is filled
// by the packet in flight. Each word is compared with the same word of the
// stored packet (read from the memory as the word is taken) and added into the
// checksum; the packet is judged on its last word in the cycle after that word
// is taken. A judged packet starts a reply run: its five words (if accepted) are
// read back from the memory's second read port, one per cycle while the output
// is not stalled, followed by the ACK or NAK reply. Words of the next packet keep
// flowing during a run; only its last word waits until the run is done. No
// clearing pass after reset: a flag marks the stored packet as all zeros until
// the first acceptance.
module alternating_bit_receiver #(
  parameter int PAYLOAD_BYTES = abr_pkg::PAYLOAD_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  abr_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output abr_pkg::out_item_t out_item
);

  localparam int NWORDS = PAYLOAD_BYTES / 4;
  localparam int IDX_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CNT_W  = $clog2(NWORDS + 2);
  localparam logic [CNT_W-1:0] CNT_WORDS = CNT_W'(NWORDS);
  localparam logic [CNT_W-1:0] CNT_OVER  = CNT_W'(NWORDS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(NWORDS - 1);

  // Sum of the four bytes of a word, each sign-extended
  function automatic logic signed [9:0] byte_sum(input logic [31:0] w);
    logic signed [9:0] s;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      s = s + 10'(signed'(w[8*i +: 8]));
    end
    return s;
  endfunction

  // Payload memory: bank x word
  logic [31:0] mem [2][NWORDS];
  logic [31:0] rda_r;
  logic [31:0] rdb_r;

  // Protocol state
  logic        expected_r, expected_nxt;
  logic        ack_bit_r, ack_bit_nxt;
  logic        prev_valid_r, prev_valid_nxt;
  logic        prev_bank_r, prev_bank_nxt;
  logic [31:0] prev_seq_r, prev_seq_nxt;
  logic [31:0] prev_ack_r, prev_ack_nxt;
  logic [31:0] prev_chk_r, prev_chk_nxt;

  // Input side
  logic             in_take;
  logic [CNT_W-1:0] word_count_r, word_count_nxt;
  logic             s0_in_range;
  logic [IDX_W-1:0] s0_idx;

  // Compare stage
  logic                s1_valid_r;
  logic                s1_last_r;
  logic                s1_first_r;
  logic                s1_in_range_r;
  logic                s1_len_ok_r;
  logic                s1_zero_r;
  abr_pkg::in_item_t   s1_item_r;
  logic signed [9:0]   s1_bsum_r;
  logic [31:0]         hdr_seq_r, hdr_ack_r, hdr_chk_r;
  logic [31:0]         sum_r, sum_nxt;
  logic                same_r, same_nxt;

  logic [31:0] hdr_seq, hdr_ack, hdr_chk;
  logic [31:0] prev_word;
  logic [31:0] sum_base, sum_new;
  logic        same_base, same_new;
  logic        judge, pkt_accept, pkt_dup;

  // Reply run
  logic             job_active_r, job_active_nxt;
  logic             job_deliver_r, job_deliver_nxt;
  logic             job_ok_r, job_ok_nxt;
  logic             job_rack_r, job_rack_nxt;
  logic [CNT_W-1:0] job_ptr_r, job_ptr_nxt;
  logic [IDX_W-1:0] rdb_idx;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  abr_pkg::out_item_t out_r, out_nxt;
  logic               out_ld;
  logic               emit_word;

  // Hold a last word until the compare stage and the reply run are free
  assign in_stall = in_item.last_word & (job_active_r | (s1_valid_r & s1_last_r));
  assign in_take  = in_valid & ~in_stall;

  assign s0_in_range = (word_count_r < CNT_WORDS);
  assign s0_idx      = s0_in_range ? word_count_r[IDX_W-1:0] : '0;

  // Advance the word counter
  always_comb begin
    word_count_nxt = word_count_r;
    if (in_take) begin
      if (in_item.last_word) begin
        word_count_nxt = '0;
      end else if (s0_in_range) begin
        word_count_nxt = word_count_r + 1'b1;
      end else begin
        word_count_nxt = CNT_OVER;
      end
    end
  end

  // Judge the packet on its last word
  always_comb begin
    hdr_seq   = s1_first_r ? s1_item_r.seq_num     : hdr_seq_r;
    hdr_ack   = s1_first_r ? s1_item_r.ack_num     : hdr_ack_r;
    hdr_chk   = s1_first_r ? s1_item_r.check_value : hdr_chk_r;
    prev_word = s1_zero_r ? '0 : rda_r;
    sum_base  = s1_first_r ? (hdr_seq + hdr_ack) : sum_r;
    same_base = s1_first_r ? ((hdr_seq == prev_seq_r) && (hdr_ack == prev_ack_r) &&
                              (hdr_chk == prev_chk_r)) : same_r;
    sum_new   = sum_base;
    same_new  = same_base;
    if (s1_in_range_r) begin
      sum_new  = sum_base + {{22{s1_bsum_r[9]}}, s1_bsum_r};
      same_new = same_base & (s1_item_r.payload_word == prev_word);
    end
    judge      = s1_valid_r & s1_last_r;
    pkt_accept = judge & s1_len_ok_r & (hdr_seq == {31'b0, expected_r}) &
                 (~sum_new == hdr_chk) & (hdr_ack == '0);
    pkt_dup    = judge & s1_len_ok_r & ~pkt_accept & same_new;
  end

  // Update the stored packet and the alternating bits
  always_comb begin
    expected_nxt   = expected_r;
    ack_bit_nxt    = ack_bit_r;
    prev_valid_nxt = prev_valid_r;
    prev_bank_nxt  = prev_bank_r;
    prev_seq_nxt   = prev_seq_r;
    prev_ack_nxt   = prev_ack_r;
    prev_chk_nxt   = prev_chk_r;
    sum_nxt        = sum_r;
    same_nxt       = same_r;
    if (s1_valid_r) begin
      sum_nxt  = sum_new;
      same_nxt = same_new;
      if (s1_last_r) begin
        sum_nxt  = '0;
        same_nxt = 1'b1;
      end
    end
    if (pkt_accept) begin
      expected_nxt   = ~expected_r;
      ack_bit_nxt    = ~ack_bit_r;
      prev_valid_nxt = 1'b1;
      prev_bank_nxt  = ~prev_bank_r;
      prev_seq_nxt   = hdr_seq;
      prev_ack_nxt   = hdr_ack;
      prev_chk_nxt   = hdr_chk;
    end
  end

  // Start and step the reply run
  assign out_ld    = job_active_r & (~out_valid_r | ~out_stall);
  assign emit_word = job_deliver_r & (job_ptr_r < CNT_WORDS);

  always_comb begin
    job_active_nxt  = job_active_r;
    job_deliver_nxt = job_deliver_r;
    job_ok_nxt      = job_ok_r;
    job_rack_nxt    = job_rack_r;
    job_ptr_nxt     = job_ptr_r;
    if (out_ld) begin
      if (emit_word) begin
        job_ptr_nxt = job_ptr_r + 1'b1;
      end else begin
        job_ptr_nxt    = '0;
        job_active_nxt = 1'b0;
      end
    end
    if (judge) begin
      job_active_nxt  = 1'b1;
      job_deliver_nxt = pkt_accept;
      job_ok_nxt      = pkt_accept | pkt_dup;
      job_rack_nxt    = ack_bit_nxt;
    end
  end

  assign rdb_idx = (job_ptr_nxt < CNT_WORDS) ? job_ptr_nxt[IDX_W-1:0] : '0;

  // Build the next result beat
  always_comb begin
    out_valid_nxt = out_ld | (out_valid_r & out_stall);
    out_nxt       = out_r;
    if (out_ld) begin
      if (emit_word) begin
        out_nxt.result_kind = abr_pkg::KIND_WORD;
        out_nxt.out_word    = rdb_r;
        out_nxt.reply_ack   = 1'b0;
        out_nxt.reply_check = '0;
        out_nxt.end_of_run  = 1'b0;
      end else begin
        out_nxt.out_word    = '0;
        out_nxt.reply_ack   = job_rack_r;
        out_nxt.end_of_run  = 1'b1;
        if (job_ok_r) begin
          out_nxt.result_kind = abr_pkg::KIND_ACK;
          out_nxt.reply_check = ~({31'b0, job_rack_r} + abr_pkg::ACK_TEXT_SUM);
        end else begin
          out_nxt.result_kind = abr_pkg::KIND_NAK;
          out_nxt.reply_check = ~({31'b0, job_rack_r} + abr_pkg::NAK_TEXT_SUM);
        end
      end
    end
  end

  // Payload memory: fill bank written, stored bank read for compare and delivery
  always_ff @(posedge clk) begin
    if (in_take && s0_in_range) begin
      mem[~prev_bank_nxt][s0_idx] <= in_item.payload_word;
    end
    rda_r <= mem[prev_bank_nxt][s0_idx];
    rdb_r <= mem[prev_bank_nxt][rdb_idx];
  end

  // Carry the beat into the compare stage
  always_ff @(posedge clk) begin
    s1_last_r     <= in_item.last_word;
    s1_first_r    <= (word_count_r == '0);
    s1_in_range_r <= s0_in_range;
    s1_len_ok_r   <= (word_count_r == CNT_LAST);
    s1_zero_r     <= ~prev_valid_nxt;
    s1_item_r     <= in_item;
    s1_bsum_r     <= byte_sum(in_item.payload_word);
    if (s1_valid_r && s1_first_r) begin
      hdr_seq_r <= s1_item_r.seq_num;
      hdr_ack_r <= s1_item_r.ack_num;
      hdr_chk_r <= s1_item_r.check_value;
    end
    out_r <= out_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r    <= 1'b0;
      ack_bit_r     <= 1'b1;
      prev_valid_r  <= 1'b0;
      prev_bank_r   <= 1'b0;
      prev_seq_r    <= '0;
      prev_ack_r    <= '0;
      prev_chk_r    <= '0;
      word_count_r  <= '0;
      s1_valid_r    <= 1'b0;
      sum_r         <= '0;
      same_r        <= 1'b1;
      job_active_r  <= 1'b0;
      job_deliver_r <= 1'b0;
      job_ok_r      <= 1'b0;
      job_rack_r    <= 1'b0;
      job_ptr_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      expected_r    <= expected_nxt;
      ack_bit_r     <= ack_bit_nxt;
      prev_valid_r  <= prev_valid_nxt;
      prev_bank_r   <= prev_bank_nxt;
      prev_seq_r    <= prev_seq_nxt;
      prev_ack_r    <= prev_ack_nxt;
      prev_chk_r    <= prev_chk_nxt;
      word_count_r  <= word_count_nxt;
      s1_valid_r    <= in_take;
      sum_r         <= sum_nxt;
      same_r        <= same_nxt;
      job_active_r  <= job_active_nxt;
      job_deliver_r <= job_deliver_nxt;
      job_ok_r      <= job_ok_nxt;
      job_rack_r    <= job_rack_nxt;
      job_ptr_r     <= job_ptr_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A packet is judged only when no reply run is in progress
  a_judge_free: assert property (@(posedge clk) disable iff (!rst_n)
    judge |-> !job_active_r)
    else $error("packet judged during a reply run");

  // A taken last word never overlaps a run or a pending judgment
  a_last_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_item.last_word |-> !job_active_r && !(s1_valid_r && s1_last_r))
    else $error("last word taken while results pending");

  // The delivery pointer stays within the packet
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    job_ptr_r <= CNT_WORDS)
    else $error("delivery pointer out of range");

  // A reply beat ends the run
  a_reply_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_ld && !emit_word |=> out_valid_r && out_r.end_of_run && !job_active_r)
    else $error("reply beat did not close the run");

endmodule

// ===== bench/abr_checker.sv =====
// Result checker for the alternating-bit receiver: predicts result beats and compares them.
`timescale 1ns / 1ps

module abr_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  abr_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  abr_pkg::out_item_t out_item,
  output int unsigned        fail_count,
  output int unsigned        owed_count
);

  localparam int NWORDS = abr_pkg::PAYLOAD_BYTES / 4;

  // Receiver state: expected sequence bit, reply ack bit, last accepted packet
  logic        expect_bit;
  logic        reply_bit;
  logic [31:0] kept_seq;
  logic [31:0] kept_ack;
  logic [31:0] kept_check;
  logic [31:0] kept_words [NWORDS];

  // Packet being assembled
  logic [31:0] open_seq;
  logic [31:0] open_ack;
  logic [31:0] open_check;
  logic [31:0] open_words [NWORDS];
  logic [31:0] open_sum;
  logic        open_matches;
  int unsigned open_count;

  abr_pkg::out_item_t owed_results [$];
  int unsigned        mismatches = 0;

  // Sum of the four bytes of a word, each sign-extended
  function automatic logic [31:0] signed_byte_sum(input logic [31:0] w);
    logic [31:0] s;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      s += {{24{w[8*i+7]}}, w[8*i +: 8]};
    end
    return s;
  endfunction

  task automatic clear_state();
    expect_bit   = 1'b0;
    reply_bit    = 1'b1;
    kept_seq     = '0;
    kept_ack     = '0;
    kept_check   = '0;
    open_seq     = '0;
    open_ack     = '0;
    open_check   = '0;
    open_sum     = '0;
    open_matches = 1'b1;
    open_count   = 0;
    for (int i = 0; i < NWORDS; i++) begin
      kept_words[i] = '0;
      open_words[i] = '0;
    end
  endtask

  task automatic owe(input abr_pkg::result_kind_t kind, input logic [31:0] word,
                     input logic rack, input logic [31:0] rchk, input logic last);
    abr_pkg::out_item_t r;
    r             = '0;
    r.result_kind = kind;
    r.out_word    = word;
    r.reply_ack   = rack;
    r.reply_check = rchk;
    r.end_of_run  = last;
    owed_results.push_back(r);
  endtask

  // Fold one payload beat into the open packet; judge it on its last word
  task automatic absorb_word(input abr_pkg::in_item_t beat);
    int unsigned slot;
    logic        length_ok;
    logic        taken;
    logic        is_dup;
    slot = open_count;
    if (slot == 0) begin
      open_seq     = beat.seq_num;
      open_ack     = beat.ack_num;
      open_check   = beat.check_value;
      open_sum     = open_seq + open_ack;
      open_matches = (open_seq == kept_seq) && (open_ack == kept_ack) &&
                     (open_check == kept_check);
    end
    if (slot < NWORDS) begin
      open_words[slot] = beat.payload_word;
      open_sum += signed_byte_sum(beat.payload_word);
      if (beat.payload_word != kept_words[slot]) open_matches = 1'b0;
      open_count = slot + 1;
    end else begin
      // drop words past the full length
      open_count = NWORDS + 1;
    end
    if (!beat.last_word) return;

    length_ok = (slot == NWORDS - 1);
    taken     = length_ok && (open_seq == {31'b0, expect_bit}) &&
                (~open_sum == open_check) && (open_ack == '0);
    is_dup    = length_ok && !taken && open_matches;

    if (taken) begin
      for (int i = 0; i < NWORDS; i++) begin
        owe(abr_pkg::KIND_WORD, open_words[i], 1'b0, '0, 1'b0);
        kept_words[i] = open_words[i];
      end
      kept_seq   = open_seq;
      kept_ack   = open_ack;
      kept_check = open_check;
      expect_bit = ~expect_bit;
      reply_bit  = ~reply_bit;
    end
    if (taken || is_dup) begin
      owe(abr_pkg::KIND_ACK, '0, reply_bit, ~(32'(reply_bit) + abr_pkg::ACK_TEXT_SUM), 1'b1);
    end else begin
      owe(abr_pkg::KIND_NAK, '0, reply_bit, ~(32'(reply_bit) + abr_pkg::NAK_TEXT_SUM), 1'b1);
    end

    open_count   = 0;
    open_sum     = '0;
    open_matches = 1'b1;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Compare one result beat against the oldest owed result
  task automatic check_result(input abr_pkg::out_item_t r);
    abr_pkg::out_item_t want;
    if (owed_results.size() == 0) begin
      report("result beat with none owed, kind/word", {r.result_kind, r.out_word[29:0]}, '0);
      return;
    end
    want = owed_results.pop_front();
    if (r.result_kind !== want.result_kind)
      report("result_kind", 32'(r.result_kind), 32'(want.result_kind));
    if (r.out_word !== want.out_word)
      report("out_word", r.out_word, want.out_word);
    if (r.reply_ack !== want.reply_ack)
      report("reply_ack", 32'(r.reply_ack), 32'(want.reply_ack));
    if (r.reply_check !== want.reply_check)
      report("reply_check", r.reply_check, want.reply_check);
    if (r.end_of_run !== want.end_of_run)
      report("end_of_run", 32'(r.end_of_run), 32'(want.end_of_run));
  endtask

  // Watch both channels at each edge; input first so a same-edge result is owed
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      owed_results.delete();
    end else begin
      if (in_valid && !in_stall) absorb_word(in_item);
      if (out_valid && !out_stall) check_result(out_item);
    end
    owed_count <= owed_results.size();
    fail_count <= mismatches;
  end

endmodule

// ===== bench/alternating_bit_receiver_test.sv =====
// Testbench top for the alternating-bit receiver: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module alternating_bit_receiver_test;

  localparam int NWORDS        = abr_pkg::PAYLOAD_BYTES / 4;
  localparam int MAX_WORDS     = 8;
  localparam int RANDOM_BEATS  = 300;
  localparam int STALL_LIMIT   = 1000;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 20;

  typedef logic [MAX_WORDS-1:0][31:0] word_set_t;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  abr_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  abr_pkg::out_item_t out_item;
  int unsigned        fail_count;
  int unsigned        owed_count;

  bit          calm        = 1'b0;
  bit          hold_wanted = 1'b0;
  bit          hold_taken  = 1'b0;
  int unsigned hold_left   = 0;
  int unsigned dead_cycles = 0;
  int unsigned beats_sent  = 0;

  // Sender's view of the link: next sequence bit and last packet it knows was taken
  logic        tx_bit;
  logic [31:0] good_seq;
  logic [31:0] good_ack;
  logic [31:0] good_check;
  word_set_t   good_words;

  always #5 clk = ~clk;

  alternating_bit_receiver dut (.*);

  abr_checker watch (.*);

  // Receiver side: random stalls, none while calm, one long hold on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_wanted && !hold_taken) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 35);
    end
  end

  // End the run when neither channel moves a beat for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) dead_cycles <= 0;
    else dead_cycles <= dead_cycles + 1;
    if (dead_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] checksum_for(input logic [31:0] seq,
                                               input logic [31:0] ackv,
                                               input word_set_t w);
    logic [31:0] s;
    s = seq + ackv;
    for (int k = 0; k < NWORDS; k++) begin
      for (int i = 0; i < 4; i++) begin
        s += {{24{w[k][8*i+7]}}, w[k][8*i +: 8]};
      end
    end
    return ~s;
  endfunction

  // Random word, biased toward sign-boundary bytes
  function automatic logic [31:0] fresh_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(3))
      2: begin
        for (int i = 0; i < 4; i++) begin
          case ($urandom_range(3))
            0: w[8*i +: 8] = 8'h00;
            1: w[8*i +: 8] = 8'h7F;
            2: w[8*i +: 8] = 8'h80;
            default: w[8*i +: 8] = 8'hFF;
          endcase
        end
      end
      3: w = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: ;
    endcase
    return w;
  endfunction

  function automatic word_set_t fresh_words();
    word_set_t w;
    for (int k = 0; k < MAX_WORDS; k++) w[k] = fresh_word();
    return w;
  endfunction

  // Offer one beat, with random idle cycles ahead of it unless calm
  task automatic put_beat(input abr_pkg::in_item_t beat);
    if (!calm) begin
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= beat;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // Header fields count only on the first word; later words carry noise there
  task automatic send_packet(input logic [31:0] seq, input logic [31:0] ackv,
                             input logic [31:0] chk, input word_set_t w,
                             input int unsigned count);
    abr_pkg::in_item_t beat;
    for (int unsigned k = 0; k < count; k++) begin
      beat.seq_num      = (k == 0) ? seq : $urandom;
      beat.ack_num      = (k == 0) ? ackv : $urandom;
      beat.check_value  = (k == 0) ? chk : $urandom;
      beat.payload_word = w[k];
      beat.last_word    = (k == count - 1);
      put_beat(beat);
    end
  endtask

  // Well-formed packet with the right sequence bit: the block takes it
  task automatic deliver_good(input word_set_t w);
    good_seq   = {31'b0, tx_bit};
    good_ack   = '0;
    good_check = checksum_for(good_seq, good_ack, w);
    good_words = w;
    send_packet(good_seq, good_ack, good_check, good_words, NWORDS);
    tx_bit = ~tx_bit;
  endtask

  // Stop offering beats until every owed result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_count != 0);
  endtask

  initial begin
    word_set_t   w;
    logic [31:0] seq;
    logic [31:0] ackv;
    logic [31:0] chk;
    int unsigned pick;
    int unsigned pkt_no;
    int unsigned count;
    int unsigned start_beats;

    tx_bit     = 1'b0;
    good_seq   = '0;
    good_ack   = '0;
    good_check = '0;
    good_words = '0;
    pkt_no     = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All-zero packet repeats the cleared stored packet: ACK without delivery
    send_packet('0, '0, '0, '0, NWORDS);
    // Accepted packet with extreme payload bytes
    w    = '0;
    w[0] = 32'hFFFF_FFFF;
    w[1] = 32'h8080_8080;
    w[2] = 32'h7F7F_7F7F;
    w[3] = 32'h0000_0000;
    w[4] = 32'h01FE_7F80;
    deliver_good(w);
    // Exact repeat of the accepted packet
    send_packet(good_seq, good_ack, good_check, good_words, NWORDS);
    // Short packet with extreme header fields
    send_packet(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, {MAX_WORDS{32'hFFFF_FFFF}}, 1);
    // Overlong packet, otherwise well formed
    w = fresh_words();
    send_packet({31'b0, tx_bit}, '0, checksum_for({31'b0, tx_bit}, '0, w), w, NWORDS + 1);

    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS) begin
      pkt_no++;
      if (pkt_no == 10) calm <= 1'b1;
      if (pkt_no == 20) calm <= 1'b0;
      if (pkt_no == 28) hold_wanted <= 1'b1;
      if (pkt_no == 36) wait_drained();

      pick = $urandom_range(99);
      if (pick < 45) begin
        deliver_good(fresh_words());
      end else if (pick < 60) begin
        // repeat the last accepted packet, now and then with one bit off
        chk = good_check;
        w   = good_words;
        if ($urandom_range(2) == 0) begin
          if ($urandom_range(1)) chk ^= 32'h1 << $urandom_range(31);
          else w[$urandom_range(NWORDS - 1)] ^= 32'h1 << $urandom_range(31);
        end
        send_packet(good_seq, good_ack, chk, w, NWORDS);
      end else begin
        w     = fresh_words();
        seq   = {31'b0, tx_bit};
        ackv  = '0;
        count = NWORDS;
        if (pick < 68) begin
          seq = {31'b0, ~tx_bit};
        end else if (pick >= 76 && pick < 83) begin
          ackv = $urandom_range(1) ? 32'h1 : 32'($urandom);
          if (ackv == '0) ackv = 32'h1;
        end else if (pick >= 83 && pick < 88) begin
          seq = $urandom;
        end else if (pick >= 88 && pick < 94) begin
          count = $urandom_range(NWORDS - 1, 1);
        end else if (pick >= 94) begin
          count = $urandom_range(MAX_WORDS, NWORDS + 1);
        end
        chk = checksum_for(seq, ackv, w);
        // corrupt the checksum field
        if (pick >= 68 && pick < 76) chk ^= 32'h1 << $urandom_range(31);
        send_packet(seq, ackv, chk, w, count);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && owed_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
